// ----- hw/rtl/ubrb_pkg.sv -----
// package for the serial byte ring buffers: depths, field widths, request codes, counter slots
`timescale 1ns / 1ps

package ubrb_pkg;

	localparam int RX_DEPTH_DEF = 1024;
	localparam int TX_DEPTH_DEF = 4096;

	localparam int BYTE_W  = 8;
	localparam int REQ_W   = 3;
	localparam int LEVEL_W = 10;
	localparam int SPACE_W = 12;
	localparam int CNT_W   = 32;

	typedef enum logic [REQ_W-1:0] {
		REQ_RX_BYTE  = 3'd0,
		REQ_RX_POP   = 3'd1,
		REQ_TX_PUSH  = 3'd2,
		REQ_TX_READY = 3'd3,
		REQ_FLUSH    = 3'd4
	} req_t;

	// statistics counter slots
	localparam int ST_OVERRUN  = 0;
	localparam int ST_FRAMING  = 1;
	localparam int ST_NOISE    = 2;
	localparam int ST_FULLDROP = 3;
	localparam int ST_RXREAD   = 4;
	localparam int ST_TXQUEUED = 5;
	localparam int ST_COUNT    = 6;

endpackage

// ----- hw/rtl/uart_byte_ring_buffers.sv -----
// top level: receive and transmit byte ring fifos with error statistics
`timescale 1ns / 1ps
//
// usage
// - command channel: an item (req_type, in_byte and the three error flags) is
//   taken at a rising edge with start high and busy low; busy stays low, so a
//   new item can be issued in every cycle
// - result channel: done is high for exactly one cycle per item, with
//   out_byte, out_valid, push_accepted, the ring levels, the armed bit and
//   the six wrapping counters as they stand after that item
// - result path: an item passes the input register, then the state update and
//   the registered store read, which also register done; throughput is one
//   item per cycle
// - the receive store and the transmit store are single-port-write arrays
//   read one address per cycle at the read pointer; each ring holds depth-1
//   bytes
// - reset clears pointers, armed bit and counters at once; the stores keep
//   whatever they hold, since a slot is only read after it was written
// - the receiver cannot stall: a result not taken in its cycle is gone
//
module uart_byte_ring_buffers
	import ubrb_pkg::*;
#(
	parameter int RX_DEPTH = RX_DEPTH_DEF,
	parameter int TX_DEPTH = TX_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [REQ_W-1:0]   req_type,
	input  logic [BYTE_W-1:0]  in_byte,
	input  logic               overrun_flag,
	input  logic               framing_flag,
	input  logic               noise_flag,
	output logic               done,
	output logic [BYTE_W-1:0]  out_byte,
	output logic               out_valid,
	output logic               push_accepted,
	output logic [LEVEL_W-1:0] rx_level,
	output logic [SPACE_W-1:0] tx_space,
	output logic               tx_armed_now,
	output logic [CNT_W-1:0]   overrun_errors,
	output logic [CNT_W-1:0]   framing_errors,
	output logic [CNT_W-1:0]   noise_errors,
	output logic [CNT_W-1:0]   full_drops,
	output logic [CNT_W-1:0]   rx_bytes_read,
	output logic [CNT_W-1:0]   tx_bytes_queued
);

	// pointer widths and widths wide enough to hold a fill level
	localparam int RX_PW = $clog2(RX_DEPTH);
	localparam int TX_PW = $clog2(TX_DEPTH);
	localparam int RX_LW = (RX_PW + 1 > LEVEL_W) ? RX_PW + 1 : LEVEL_W;
	localparam int TX_LW = (TX_PW + 1 > SPACE_W) ? TX_PW + 1 : SPACE_W;
	localparam logic [RX_PW-1:0] RX_LAST = RX_PW'(RX_DEPTH - 1);
	localparam logic [TX_PW-1:0] TX_LAST = TX_PW'(TX_DEPTH - 1);

	// input register
	logic              valid_s1;
	req_t              req_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              overrun_s1;
	logic              framing_s1;
	logic              noise_s1;

	// ring state
	logic [RX_PW-1:0] rx_wr_ptr_q;
	logic [RX_PW-1:0] rx_rd_ptr_q;
	logic [TX_PW-1:0] tx_wr_ptr_q;
	logic [TX_PW-1:0] tx_rd_ptr_q;
	logic             tx_armed_q;
	logic [CNT_W-1:0] stat_q [ST_COUNT];

	// byte stores
	logic [BYTE_W-1:0] rx_mem [RX_DEPTH];
	logic [BYTE_W-1:0] tx_mem [TX_DEPTH];

	// result register
	logic              done_s2;
	logic              out_valid_s2;
	logic              push_acc_s2;
	logic              from_tx_s2;
	logic [BYTE_W-1:0] rx_data_s2;
	logic [BYTE_W-1:0] tx_data_s2;

	// update logic
	logic [RX_PW-1:0] rx_wr_nx;
	logic [RX_PW-1:0] rx_rd_nx;
	logic [TX_PW-1:0] tx_wr_nx;
	logic [TX_PW-1:0] tx_rd_nx;
	logic             rx_full;
	logic             rx_empty;
	logic             tx_full;
	logic             tx_empty;
	logic             rx_we;
	logic             rx_re;
	logic             tx_we;
	logic             tx_re;
	logic             arm_set;
	logic             arm_clr;
	logic [ST_COUNT-1:0] stat_inc;

	// level outputs
	logic [RX_PW:0]    rx_used;
	logic [TX_PW:0]    tx_used;
	logic [RX_LW-1:0]  rx_used_w;
	logic [TX_LW-1:0]  tx_free_w;

	// the block takes one item every cycle
	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	// payload of the input register needs no reset
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			req_s1     <= req_t'(req_type);
			byte_s1    <= in_byte;
			overrun_s1 <= overrun_flag;
			framing_s1 <= framing_flag;
			noise_s1   <= noise_flag;
		end
	end

	// next slot after each pointer, wrapping at the ring depth
	assign rx_wr_nx = (rx_wr_ptr_q == RX_LAST) ? '0 : rx_wr_ptr_q + 1'b1;
	assign rx_rd_nx = (rx_rd_ptr_q == RX_LAST) ? '0 : rx_rd_ptr_q + 1'b1;
	assign tx_wr_nx = (tx_wr_ptr_q == TX_LAST) ? '0 : tx_wr_ptr_q + 1'b1;
	assign tx_rd_nx = (tx_rd_ptr_q == TX_LAST) ? '0 : tx_rd_ptr_q + 1'b1;

	assign rx_full  = (rx_wr_nx == rx_rd_ptr_q);
	assign rx_empty = (rx_rd_ptr_q == rx_wr_ptr_q);
	assign tx_full  = (tx_wr_nx == tx_rd_ptr_q);
	assign tx_empty = (tx_rd_ptr_q == tx_wr_ptr_q);

	// decode the registered item into store accesses and counter bumps
	always_comb begin
		rx_we    = 1'b0;
		rx_re    = 1'b0;
		tx_we    = 1'b0;
		tx_re    = 1'b0;
		arm_set  = 1'b0;
		arm_clr  = 1'b0;
		stat_inc = '0;
		if (valid_s1) begin
			case (req_s1)
				REQ_RX_BYTE: begin
					stat_inc[ST_OVERRUN] = overrun_s1;
					stat_inc[ST_FRAMING] = framing_s1;
					stat_inc[ST_NOISE]   = noise_s1;
					// a byte with a framing or noise error is thrown away
					if (!framing_s1 && !noise_s1) begin
						rx_we                 = !rx_full;
						stat_inc[ST_FULLDROP] = rx_full;
					end
				end
				REQ_RX_POP: begin
					rx_re               = !rx_empty;
					stat_inc[ST_RXREAD] = !rx_empty;
				end
				REQ_TX_PUSH: begin
					tx_we                 = !tx_full;
					arm_set               = !tx_full;
					stat_inc[ST_TXQUEUED] = !tx_full;
				end
				REQ_TX_READY: begin
					// armed with a byte queued: send it; armed and nothing left to send: go idle
					tx_re   = tx_armed_q && !tx_empty;
					arm_clr = tx_armed_q && tx_empty;
				end
				REQ_FLUSH: begin
					arm_set = !tx_empty;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_wr_ptr_q <= '0;
			rx_rd_ptr_q <= '0;
			tx_wr_ptr_q <= '0;
			tx_rd_ptr_q <= '0;
			tx_armed_q  <= 1'b0;
			for (int i = 0; i < ST_COUNT; i++) begin
				stat_q[i] <= '0;
			end
		end else begin
			if (rx_we) begin
				rx_wr_ptr_q <= rx_wr_nx;
			end
			if (rx_re) begin
				rx_rd_ptr_q <= rx_rd_nx;
			end
			if (tx_we) begin
				tx_wr_ptr_q <= tx_wr_nx;
			end
			if (tx_re) begin
				tx_rd_ptr_q <= tx_rd_nx;
			end
			if (arm_set) begin
				tx_armed_q <= 1'b1;
			end else if (arm_clr) begin
				tx_armed_q <= 1'b0;
			end
			// counters wrap naturally at their width
			for (int i = 0; i < ST_COUNT; i++) begin
				if (stat_inc[i]) begin
					stat_q[i] <= stat_q[i] + 1'b1;
				end
			end
		end
	end

	// stores: one write and one registered read per cycle each; a read slot
	// is always behind the write pointer, so it was written in an earlier cycle
	always_ff @(posedge clk) begin
		if (rx_we) begin
			rx_mem[rx_wr_ptr_q] <= byte_s1;
		end
		if (rx_re) begin
			rx_data_s2 <= rx_mem[rx_rd_ptr_q];
		end
	end

	always_ff @(posedge clk) begin
		if (tx_we) begin
			tx_mem[tx_wr_ptr_q] <= byte_s1;
		end
		if (tx_re) begin
			tx_data_s2 <= tx_mem[tx_rd_ptr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s2      <= 1'b0;
			out_valid_s2 <= 1'b0;
			push_acc_s2  <= 1'b0;
			from_tx_s2   <= 1'b0;
		end else begin
			done_s2      <= valid_s1;
			out_valid_s2 <= rx_re || tx_re;
			push_acc_s2  <= rx_we || tx_we;
			from_tx_s2   <= tx_re;
		end
	end

	// fill levels from the updated pointers
	always_comb begin
		if (rx_wr_ptr_q >= rx_rd_ptr_q) begin
			rx_used = {1'b0, rx_wr_ptr_q} - {1'b0, rx_rd_ptr_q};
		end else begin
			rx_used = (RX_PW + 1)'(RX_DEPTH) - {1'b0, rx_rd_ptr_q} + {1'b0, rx_wr_ptr_q};
		end
		if (tx_wr_ptr_q >= tx_rd_ptr_q) begin
			tx_used = {1'b0, tx_wr_ptr_q} - {1'b0, tx_rd_ptr_q};
		end else begin
			tx_used = (TX_PW + 1)'(TX_DEPTH) - {1'b0, tx_rd_ptr_q} + {1'b0, tx_wr_ptr_q};
		end
		rx_used_w = RX_LW'(rx_used);
		tx_free_w = TX_LW'(TX_DEPTH - 1) - TX_LW'(tx_used);
	end

	// result ports; the state registers already hold the post-item values
	assign done            = done_s2;
	assign out_valid       = out_valid_s2;
	assign push_accepted   = push_acc_s2;
	assign out_byte        = !out_valid_s2 ? '0 : (from_tx_s2 ? tx_data_s2 : rx_data_s2);
	assign rx_level        = rx_used_w[LEVEL_W-1:0];
	assign tx_space        = tx_free_w[SPACE_W-1:0];
	assign tx_armed_now    = tx_armed_q;
	assign overrun_errors  = stat_q[ST_OVERRUN];
	assign framing_errors  = stat_q[ST_FRAMING];
	assign noise_errors    = stat_q[ST_NOISE];
	assign full_drops      = stat_q[ST_FULLDROP];
	assign rx_bytes_read   = stat_q[ST_RXREAD];
	assign tx_bytes_queued = stat_q[ST_TXQUEUED];

`ifndef SYNTHESIS
	// one item never both stores and returns a byte
	a_store_xor_return: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(out_valid && push_accepted))
		else $error("item both stored and returned a byte");

	// a ring never holds more than depth-1 bytes
	a_rx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rx_used <= (RX_PW + 1)'(RX_DEPTH - 1))
		else $error("receive ring over capacity");

	a_tx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		tx_used <= (TX_PW + 1)'(TX_DEPTH - 1))
		else $error("transmit ring over capacity");

	// sending a byte leaves the transmitter armed
	a_send_armed: assert property (@(posedge clk) disable iff (!arst_n)
		(done && out_valid && from_tx_s2) |-> tx_armed_now)
		else $error("byte sent while transmitter disarmed");

	// a result follows every taken item, after the input and result registers
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> ##1 done)
		else $error("taken item produced no result");
`endif

endmodule

// ----- dv/tb.sv -----
// self-checking testbench for the serial byte ring buffers
`timescale 1ns / 1ps

module tb;
	import ubrb_pkg::*;

	// request codes past flush are unused: the block must leave its state alone
	localparam logic [REQ_W-1:0] REQ_UNUSED_FIRST = REQ_W'(REQ_FLUSH + 1);
	localparam logic [REQ_W-1:0] REQ_UNUSED_LAST  = '1;

	localparam int STALL_LIMIT  = 1000; // cycles with no item and no result
	localparam int TAIL_CYCLES  = 8;    // plenty of margin after the last result
	localparam int MAX_SHOWN    = 10;
	localparam int MIX_ITEMS    = 80;   // per free-running random phase
	localparam int MAX_GAP      = 9;

	// one command as the sender queues it
	typedef struct {
		logic [REQ_W-1:0]  req;
		logic [BYTE_W-1:0] data;
		logic              ovr;
		logic              frm;
		logic              nse;
		int unsigned       gap;         // idle cycles after this item is taken
		bit                drain_first; // hold it back until every result is in
	} link_cmd_t;

	// one status result as the block reports it
	typedef struct {
		logic [BYTE_W-1:0]                data;
		logic                             valid;
		logic                             stored;
		logic [LEVEL_W-1:0]               level;
		logic [SPACE_W-1:0]               space;
		logic                             armed;
		logic [ST_COUNT-1:0][CNT_W-1:0]   stats;
	} link_status_t;

	// clock, reset and block inputs, all known from time zero
	logic               clk          = 1'b0;
	logic               arst_n       = 1'b0;
	logic               start        = 1'b0;
	logic [REQ_W-1:0]   req_type     = '0;
	logic [BYTE_W-1:0]  in_byte      = '0;
	logic               overrun_flag = 1'b0;
	logic               framing_flag = 1'b0;
	logic               noise_flag   = 1'b0;

	logic               busy;
	logic               done;
	logic [BYTE_W-1:0]  out_byte;
	logic               out_valid;
	logic               push_accepted;
	logic [LEVEL_W-1:0] rx_level;
	logic [SPACE_W-1:0] tx_space;
	logic               tx_armed_now;
	logic [CNT_W-1:0]   overrun_errors;
	logic [CNT_W-1:0]   framing_errors;
	logic [CNT_W-1:0]   noise_errors;
	logic [CNT_W-1:0]   full_drops;
	logic [CNT_W-1:0]   rx_bytes_read;
	logic [CNT_W-1:0]   tx_bytes_queued;

	uart_byte_ring_buffers dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.req_type        (req_type),
		.in_byte         (in_byte),
		.overrun_flag    (overrun_flag),
		.framing_flag    (framing_flag),
		.noise_flag      (noise_flag),
		.done            (done),
		.out_byte        (out_byte),
		.out_valid       (out_valid),
		.push_accepted   (push_accepted),
		.rx_level        (rx_level),
		.tx_space        (tx_space),
		.tx_armed_now    (tx_armed_now),
		.overrun_errors  (overrun_errors),
		.framing_errors  (framing_errors),
		.noise_errors    (noise_errors),
		.full_drops      (full_drops),
		.rx_bytes_read   (rx_bytes_read),
		.tx_bytes_queued (tx_bytes_queued)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// ring model: its own stores, pointers, armed bit and counters
	// ------------------------------------------------------------------
	logic [BYTE_W-1:0]              rx_mem [RX_DEPTH_DEF];
	logic [BYTE_W-1:0]              tx_mem [TX_DEPTH_DEF];
	int unsigned                    rx_head = 0; // write side
	int unsigned                    rx_tail = 0; // read side
	int unsigned                    tx_head = 0;
	int unsigned                    tx_tail = 0;
	bit                             tx_on   = 1'b0;
	logic [ST_COUNT-1:0][CNT_W-1:0] link_stats = '0;

	function automatic int unsigned ring_advance(int unsigned p, int unsigned depth);
		return (p + 1 >= depth) ? 0 : p + 1;
	endfunction

	function automatic int unsigned ring_fill(int unsigned wr, int unsigned rd,
			int unsigned depth);
		return (wr >= rd) ? wr - rd : depth - rd + wr;
	endfunction

	// apply one command to the model and return the status it must produce
	function automatic link_status_t predict_status(link_cmd_t c);
		link_status_t r;
		int unsigned  nxt;
		r.data   = '0;
		r.valid  = 1'b0;
		r.stored = 1'b0;
		case (c.req)
			REQ_RX_BYTE: begin
				// every flag is counted, but only framing and noise kill the byte
				if (c.ovr)
					link_stats[ST_OVERRUN] = link_stats[ST_OVERRUN] + 1'b1;
				if (c.frm)
					link_stats[ST_FRAMING] = link_stats[ST_FRAMING] + 1'b1;
				if (c.nse)
					link_stats[ST_NOISE] = link_stats[ST_NOISE] + 1'b1;
				if (!c.frm && !c.nse) begin
					nxt = ring_advance(rx_head, RX_DEPTH_DEF);
					if (nxt != rx_tail) begin
						rx_mem[rx_head] = c.data;
						rx_head = nxt;
						r.stored = 1'b1;
					end else begin
						link_stats[ST_FULLDROP] = link_stats[ST_FULLDROP] + 1'b1;
					end
				end
			end
			REQ_RX_POP: begin
				if (rx_tail != rx_head) begin
					r.data  = rx_mem[rx_tail];
					r.valid = 1'b1;
					rx_tail = ring_advance(rx_tail, RX_DEPTH_DEF);
					link_stats[ST_RXREAD] = link_stats[ST_RXREAD] + 1'b1;
				end
			end
			REQ_TX_PUSH: begin
				// a refused push leaves the armed bit as it was
				nxt = ring_advance(tx_head, TX_DEPTH_DEF);
				if (nxt != tx_tail) begin
					tx_mem[tx_head] = c.data;
					tx_head = nxt;
					r.stored = 1'b1;
					link_stats[ST_TXQUEUED] = link_stats[ST_TXQUEUED] + 1'b1;
					tx_on = 1'b1;
				end
			end
			REQ_TX_READY: begin
				// ignored while disarmed; an empty ring disarms
				if (tx_on) begin
					if (tx_tail != tx_head) begin
						r.data  = tx_mem[tx_tail];
						r.valid = 1'b1;
						tx_tail = ring_advance(tx_tail, TX_DEPTH_DEF);
					end else begin
						tx_on = 1'b0;
					end
				end
			end
			REQ_FLUSH: begin
				if (tx_tail != tx_head)
					tx_on = 1'b1;
			end
			default: begin
				// unused codes change nothing
			end
		endcase
		r.level = LEVEL_W'(ring_fill(rx_head, rx_tail, RX_DEPTH_DEF));
		r.space = SPACE_W'(TX_DEPTH_DEF - 1 - ring_fill(tx_head, tx_tail, TX_DEPTH_DEF));
		r.armed = tx_on;
		r.stats = link_stats;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// stimulus: the initial block below fills cmd_queue, the driver drains it
	// ------------------------------------------------------------------
	link_cmd_t    cmd_queue[$];
	link_status_t status_expect[$];
	bit           sender_quiet = 1'b0; // no idle cycles while set
	bit           pause_next   = 1'b0; // next command waits for all results
	int unsigned  mismatches   = 0;

	task automatic add_cmd(logic [REQ_W-1:0] req, logic [BYTE_W-1:0] data,
			logic ovr, logic frm, logic nse);
		link_cmd_t c;
		c.req         = req;
		c.data        = data;
		c.ovr         = ovr;
		c.frm         = frm;
		c.nse         = nse;
		c.gap         = sender_quiet ? 0 : $urandom_range(0, MAX_GAP);
		c.drain_first = pause_next;
		pause_next    = 1'b0;
		cmd_queue.push_back(c);
	endtask

	// weighted random commands; what is left after the four weights is split
	// between flush and unused codes. receive flags are set with odds
	// 1 in (flag_odds + 1); on other requests they are plain random bits
	task automatic add_mix(int unsigned count, int unsigned rx_pct, int unsigned pop_pct,
			int unsigned push_pct, int unsigned ready_pct, int unsigned flag_odds);
		int unsigned      roll;
		logic [REQ_W-1:0] req;
		for (int i = 0; i < count; i++) begin
			// long runs of back-to-back items now and then
			if (i % 40 == 0)
				sender_quiet = ($urandom_range(0, 3) == 0);
			roll = $urandom_range(0, 99);
			if (roll < rx_pct)
				req = REQ_RX_BYTE;
			else if (roll < rx_pct + pop_pct)
				req = REQ_RX_POP;
			else if (roll < rx_pct + pop_pct + push_pct)
				req = REQ_TX_PUSH;
			else if (roll < rx_pct + pop_pct + push_pct + ready_pct)
				req = REQ_TX_READY;
			else if ($urandom_range(0, 1) == 0)
				req = REQ_FLUSH;
			else
				req = REQ_W'($urandom_range(REQ_UNUSED_FIRST, REQ_UNUSED_LAST));
			if (req == REQ_RX_BYTE)
				add_cmd(req, BYTE_W'($urandom_range(0, 255)),
					$urandom_range(0, flag_odds) == 0,
					$urandom_range(0, flag_odds) == 0,
					$urandom_range(0, flag_odds) == 0);
			else
				add_cmd(req, BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
		end
		sender_quiet = 1'b0;
	endtask

	initial begin
		// --- directed part ---
		// ready while disarmed, pop from an empty ring, flush with nothing queued
		add_cmd(REQ_TX_READY, 8'h00, 1'b0, 1'b0, 1'b0);
		add_cmd(REQ_RX_POP, 8'hff, 1'b1, 1'b1, 1'b1);
		add_cmd(REQ_FLUSH, 8'h00, 1'b0, 1'b0, 1'b0);
		// unused request codes, all flags up: no counter may move
		for (int q = REQ_UNUSED_FIRST; q <= REQ_UNUSED_LAST; q++)
			add_cmd(REQ_W'(q), 8'hff, 1'b1, 1'b1, 1'b1);
		// receive: clean, overrun only (still stored), framing, noise, everything
		add_cmd(REQ_RX_BYTE, 8'h00, 1'b0, 1'b0, 1'b0);
		add_cmd(REQ_RX_BYTE, 8'hff, 1'b1, 1'b0, 1'b0);
		add_cmd(REQ_RX_BYTE, 8'h5a, 1'b0, 1'b1, 1'b0);
		add_cmd(REQ_RX_BYTE, 8'ha5, 1'b0, 1'b0, 1'b1);
		add_cmd(REQ_RX_BYTE, 8'h3c, 1'b1, 1'b1, 1'b1);
		// transmit pushes arm the sender; flags here must be ignored
		add_cmd(REQ_TX_PUSH, 8'hff, 1'b1, 1'b1, 1'b1);
		add_cmd(REQ_TX_PUSH, 8'h00, 1'b0, 1'b0, 1'b0);
		add_cmd(REQ_FLUSH, 8'h00, 1'b1, 1'b0, 1'b0);
		// two sends, then ready on an empty ring disarms, then one is ignored
		repeat (4) add_cmd(REQ_TX_READY, 8'h00, 1'b0, 1'b0, 1'b0);
		// read back both stored bytes, the third pop finds the ring empty
		repeat (3) add_cmd(REQ_RX_POP, 8'h00, 1'b0, 1'b0, 1'b0);

		// --- random traffic with both rings shallow ---
		add_mix(MIX_ITEMS, 35, 20, 20, 15, 5);

		// --- receive ring filled deeper, then drained ---
		pause_next = 1'b1;
		add_mix(60, 95, 3, 1, 1, 30);
		add_mix(60, 5, 90, 2, 2, 5);

		// --- transmit ring filled deeper, then sent out ---
		pause_next = 1'b1;
		add_mix(60, 1, 1, 97, 1, 5);
		add_mix(60, 1, 1, 2, 96, 5);

		// --- random traffic again ---
		add_mix(MIX_ITEMS, 35, 20, 20, 15, 5);

		// single reset at the start of the run
		repeat (8) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// wait for the driver to run dry, then for the last results
		while (cmd_queue.size() != 0 || start)
			@(negedge clk);
		while (status_expect.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
		mismatches += status_expect.size();

		if (mismatches == 0) begin
			$display("tb: clean");
		end else begin
			$display("tb: errors");
		end
		$finish;
	end

	// ------------------------------------------------------------------
	// driver: presents items at the falling edge, honors gaps and pauses
	// ------------------------------------------------------------------
	bit          item_taken = 1'b0; // the item on the ports went in at the last edge
	int unsigned gap_left   = 0;

	always @(negedge clk) begin
		link_cmd_t c;
		if (arst_n) begin
			if (start && !item_taken) begin
				// busy held it off: keep the same item up
			end else if (gap_left != 0) begin
				start    <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (cmd_queue.size() == 0 ||
					(cmd_queue[0].drain_first && status_expect.size() != 0)) begin
				start <= 1'b0;
			end else begin
				c = cmd_queue.pop_front();
				req_type     <= c.req;
				in_byte      <= c.data;
				overrun_flag <= c.ovr;
				framing_flag <= c.frm;
				noise_flag   <= c.nse;
				gap_left     <= c.gap;
				start        <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// monitor: checks results against the model, then logs new items
	// ------------------------------------------------------------------
	task automatic log_mismatch(string what, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
		if (mismatches < MAX_SHOWN)
			$display("tb: mismatch at %0t, %s: expected %0h, got %0h", $realtime, what,
				want, got);
		mismatches++;
	endtask

	always @(posedge clk) begin
		link_status_t               want;
		link_cmd_t                  seen;
		logic [ST_COUNT-1:0][CNT_W-1:0] got_stats;
		if (arst_n) begin
			if (done) begin
				if (status_expect.size() == 0) begin
					log_mismatch("result with no item pending, out_byte", '0,
						CNT_W'(out_byte));
				end else begin
					want = status_expect.pop_front();
					got_stats[ST_OVERRUN]  = overrun_errors;
					got_stats[ST_FRAMING]  = framing_errors;
					got_stats[ST_NOISE]    = noise_errors;
					got_stats[ST_FULLDROP] = full_drops;
					got_stats[ST_RXREAD]   = rx_bytes_read;
					got_stats[ST_TXQUEUED] = tx_bytes_queued;
					if (out_byte !== want.data)
						log_mismatch("out_byte", CNT_W'(want.data), CNT_W'(out_byte));
					if (out_valid !== want.valid)
						log_mismatch("out_valid", CNT_W'(want.valid), CNT_W'(out_valid));
					if (push_accepted !== want.stored)
						log_mismatch("push_accepted", CNT_W'(want.stored),
							CNT_W'(push_accepted));
					if (rx_level !== want.level)
						log_mismatch("rx_level", CNT_W'(want.level), CNT_W'(rx_level));
					if (tx_space !== want.space)
						log_mismatch("tx_space", CNT_W'(want.space), CNT_W'(tx_space));
					if (tx_armed_now !== want.armed)
						log_mismatch("tx_armed_now", CNT_W'(want.armed),
							CNT_W'(tx_armed_now));
					// counters in slot order: overrun, framing, noise, drops, read, queued
					for (int k = 0; k < ST_COUNT; k++)
						if (got_stats[k] !== want.stats[k])
							log_mismatch($sformatf("counter slot %0d", k), want.stats[k],
								got_stats[k]);
				end
			end
			if (start && !busy) begin
				seen.req         = req_type;
				seen.data        = in_byte;
				seen.ovr         = overrun_flag;
				seen.frm         = framing_flag;
				seen.nse         = noise_flag;
				seen.gap         = 0;
				seen.drain_first = 1'b0;
				status_expect.push_back(predict_status(seen));
			end
			item_taken <= start && !busy;
		end else begin
			item_taken <= 1'b0;
		end
	end

	// ------------------------------------------------------------------
	// watchdog: too long with neither an item taken nor a result seen
	// ------------------------------------------------------------------
	int unsigned stall_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done) begin
				stall_cycles <= 0;
			end else if (stall_cycles >= STALL_LIMIT) begin
				$display("tb: errors");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

endmodule
